// ----- design/sbpl_pkg.sv -----
// sbpl_pkg: shared types and codes for the sized buffer pool allocator
// no dependencies; used by the interfaces, the slot memory and the top level
package sbpl_pkg;

  localparam int CMD_W      = 2;
  localparam int CH_W       = 8;
  localparam int SM_W       = 16;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int ACTIVE_W   = 5;
  localparam int LIMIT_W    = 5;
  localparam int STAMP_W    = 32;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ALL      = 3'd6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // one slot's stored size and last-use stamp
  typedef struct packed {
    logic [CH_W-1:0]    channels;
    logic [SM_W-1:0]    samples;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

endpackage

// ----- design/sbpl_if.sv -----
// sbpl_if: valid/ready channels for requests, results and the limit register
// depends on sbpl_pkg for field widths
interface sbpl_req_if;
  import sbpl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CH_W-1:0]   channels;
  logic [SM_W-1:0]   samples;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, cmd, channels, samples, slot, input ready);
  modport sink (input valid, cmd, channels, samples, slot, output ready);
endinterface

interface sbpl_rsp_if;
  import sbpl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_slot;
  logic                needs_clear;
  logic [ACTIVE_W-1:0] active_count;
  modport source (output valid, status, granted_slot, needs_clear, active_count,
                  input ready);
  modport sink (input valid, status, granted_slot, needs_clear, active_count,
                output ready);
endinterface

interface sbpl_cfg_if;
  import sbpl_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/sbpl_slot_mem.sv -----
// sbpl_slot_mem: per-slot size and stamp storage, one write and one registered read port
// depends on sbpl_pkg for slot_entry_t
module sbpl_slot_mem #(
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  sbpl_pkg::slot_entry_t      wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output sbpl_pkg::slot_entry_t      rd_data
);
  import sbpl_pkg::*;

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/sized_buffer_pool_lru_allocator_unit.sv -----
// sized_buffer_pool_lru_allocator_unit: buffer slot pool with exact-size match,
// append and least-recently-used reuse; depends on sbpl_pkg, sbpl_if, sbpl_slot_mem
//
// usage
//   req  : one beat per command (acquire, release one slot, release all)
//   rsp  : exactly one beat per accepted command, in order
//   cfg  : writes the pool limit (max_entries); ready outside reset, write only when idle
// timing
//   acquire: one shared age subtract/compare unit walks the slot memory, one entry
//   a cycle, behind its registered read port, then the decide state writes the grant
//   and the done state loads the result into the output register
//   release, release-all and unknown commands: the result goes through the done
//   state into the output register; req.ready is high only while idle and out of
//   reset, from the cycle after the result loads, so commands are taken one at a time
// reset
//   rst clears the busy and present bits, fill, busy count and frame counter and
//   sets the limit to 16; slot sizes and stamps are left as they are
// stalls
//   the result sits in an output register; a new command is taken while it waits,
//   and the sequencer holds in its done state until the register frees up
module sized_buffer_pool_lru_allocator_unit #(
  parameter int POOL_SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  sbpl_req_if.sink  req,
  sbpl_rsp_if.source rsp,
  sbpl_cfg_if.sink  cfg
);
  import sbpl_pkg::*;

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]          state;
  logic [LIMIT_W-1:0]  max_entries;
  logic [POOL_SLOTS-1:0] present;
  logic [POOL_SLOTS-1:0] busy;
  logic [STAMP_W-1:0]  frame;
  logic [CNT_W-1:0]    pool_fill;
  logic [CNT_W-1:0]    busy_total;

  // latched request
  logic [CH_W-1:0]     req_ch;
  logic [SM_W-1:0]     req_sm;

  // scan bookkeeping
  logic [CNT_W-1:0]    issue_cnt;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;
  logic                found;
  logic [IDX_W-1:0]    match_idx;
  logic                have;
  logic [IDX_W-1:0]    best_idx;
  logic [STAMP_W-1:0]  best_age;

  // result held until the output register takes it
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_clear;
  logic [ACTIVE_W-1:0] res_active;

  // slot memory ports
  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  slot_entry_t         mem_wr_data;
  slot_entry_t         mem_rd_data;

  // shared age unit and compare
  logic [STAMP_W-1:0]  age;
  logic                slot_free;
  logic                size_hit;
  logic [CMP_W-1:0]    limit;
  logic                fill_ok;
  logic                req_fire;
  logic                rsp_load;
  logic [IDX_W-1:0]    rel_idx;
  logic                rel_ok;
  logic [IDX_W-1:0]    grant_idx;
  logic                grant_any;

  assign req.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign req_fire  = req.valid && req.ready;
  assign rsp_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign age       = frame - mem_rd_data.stamp;
  assign slot_free = present[rd_idx] && !busy[rd_idx];
  assign size_hit  = (mem_rd_data.channels == req_ch) && (mem_rd_data.samples == req_sm);

  // limit capped at the physical pool size
  assign limit   = (CMP_W'(max_entries) < CMP_W'(POOL_SLOTS)) ? CMP_W'(max_entries)
                                                              : CMP_W'(POOL_SLOTS);
  assign fill_ok = CMP_W'(pool_fill) < limit;

  // release index range and state check
  assign rel_idx = IDX_W'(req.slot);
  assign rel_ok  = (int'(req.slot) < POOL_SLOTS) && present[rel_idx] && busy[rel_idx];

  // grant choice: exact match, then append, then lru reuse
  always_comb begin
    grant_any = 1'b1;
    if (found) begin
      grant_idx = match_idx;
    end else if (fill_ok) begin
      grant_idx = IDX_W'(pool_fill);
    end else begin
      grant_idx = best_idx;
      grant_any = have;
    end
  end

  assign mem_wr_en            = (state == S_DECIDE) && grant_any;
  assign mem_wr_addr          = grant_idx;
  assign mem_wr_data.channels = req_ch;
  assign mem_wr_data.samples  = req_sm;
  assign mem_wr_data.stamp    = frame;

  sbpl_slot_mem #(
    .DEPTH  (POOL_SLOTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_entries <= LIMIT_RESET;
      present     <= '0;
      busy        <= '0;
      frame       <= '0;
      pool_fill   <= '0;
      busy_total  <= '0;
      issue_cnt   <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      have        <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_entries <= cfg.data;
      end
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            req_ch     <= req.channels;
            req_sm     <= req.samples;
            res_slot   <= '0;
            res_clear  <= 1'b0;
            case (req.cmd)
              CMD_ACQUIRE: begin
                frame      <= frame + 1'b1;
                res_active <= ACTIVE_W'(busy_total);
                issue_cnt  <= '0;
                rd_valid   <= 1'b0;
                found      <= 1'b0;
                have       <= 1'b0;
                state      <= S_SCAN;
              end
              CMD_RELEASE: begin
                if (rel_ok) begin
                  busy[rel_idx] <= 1'b0;
                  busy_total    <= busy_total - 1'b1;
                  res_active    <= ACTIVE_W'(busy_total - 1'b1);
                  res_status    <= ST_RELEASED;
                end else begin
                  res_active <= ACTIVE_W'(busy_total);
                  res_status <= ST_IGNORED;
                end
                state <= S_DONE;
              end
              CMD_RELEASE_ALL: begin
                busy       <= '0;
                busy_total <= '0;
                res_active <= '0;
                res_status <= ST_ALL;
                state      <= S_DONE;
              end
              default: begin
                res_active <= ACTIVE_W'(busy_total);
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue one read a cycle, judge the entry read the cycle before
          if (issue_cnt != CNT_W'(POOL_SLOTS)) begin
            rd_idx    <= issue_cnt[IDX_W-1:0];
            issue_cnt <= issue_cnt + 1'b1;
            rd_valid  <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid) begin
              state <= S_DECIDE;
            end
          end
          if (rd_valid && slot_free) begin
            if (!found && size_hit) begin
              found     <= 1'b1;
              match_idx <= rd_idx;
            end
            if (!have || age > best_age) begin
              have     <= 1'b1;
              best_idx <= rd_idx;
              best_age <= age;
            end
          end
        end

        S_DECIDE: begin
          // res_slot was cleared when the acquire was taken
          if (grant_any) begin
            present[grant_idx] <= 1'b1;
            busy[grant_idx]    <= 1'b1;
            busy_total         <= busy_total + 1'b1;
            res_active         <= ACTIVE_W'(busy_total + 1'b1);
            res_slot           <= SLOT_W'(grant_idx);
          end
          if (found) begin
            res_status <= ST_MATCHED;
            res_clear  <= 1'b1;
          end else if (fill_ok) begin
            res_status <= ST_NEW;
            pool_fill  <= pool_fill + 1'b1;
          end else if (have) begin
            res_status <= ST_REUSED;
            res_clear  <= 1'b1;
          end else begin
            res_status <= ST_NONE;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (rsp_load) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.granted_slot <= res_slot;
            rsp.needs_clear  <= res_clear;
            rsp.active_count <= res_active;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the busy count tracks the busy bits
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    $countones(busy) == int'(busy_total))
    else $error("busy_total out of step with busy bits");

  // only present slots can be busy
  a_busy_present: assert property (@(posedge clk) disable iff (rst)
    (busy & ~present) == '0)
    else $error("busy slot not present");

  // slots are appended in order, so present bits equal the fill count
  a_fill_present: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(pool_fill))
    else $error("pool_fill out of step with present bits");

  // an acquire advances the frame counter by one
  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.cmd == CMD_ACQUIRE) |=> frame == $past(frame) + 1'b1)
    else $error("frame counter did not advance on acquire");

  // a granted slot is busy once the result is ready
  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) && grant_any |=> busy[$past(grant_idx)])
    else $error("granted slot not marked busy");
`endif

endmodule
